FILE: design/tlfps_pkg.sv
// package for the two-led flash pattern sequencer
// shared widths, mode limit, debounce counts and the pattern state record
package tlfps_pkg;

    localparam int LastMode   = 25;
    localparam int PressRun   = 3;
    localparam int ReleaseRun = 60;

    typedef struct packed {
        logic [4:0]  mode;
        logic [11:0] duty_timer_a;
        logic [11:0] duty_timer_b;
        logic [7:0]  blink_level_a;
        logic [7:0]  blink_level_b;
        logic [7:0]  blink_count_a;
        logic [7:0]  blink_count_b;
        logic [9:0]  start_delay;
        logic [1:0]  pattern_phase;
        logic [7:0]  step_counter;
        logic [1:0]  selected_led;
        logic [1:0]  selected_mask;
        logic [2:0]  switch_count;
        logic [5:0]  last_quarter_count;
        logic [1:0]  first_led_phase;
        logic        first_led_subphase;
        logic [1:0]  first_led_rounds;
        logic [1:0]  second_led_phase;
        logic        second_led_subphase;
        logic [1:0]  second_led_rounds;
        logic [1:0]  drive;
    } pat_state_t;

    typedef struct packed {
        logic [1:0] press_run;
        logic [5:0] release_run;
        logic       held;
    } deb_state_t;

endpackage

FILE: design/tlfps_debounce.sv
// key debouncer: asymmetric press and release run counters
// depends on tlfps_pkg
module tlfps_debounce #(
    parameter int PRESS_RUN   = tlfps_pkg::PressRun,
    parameter int RELEASE_RUN = tlfps_pkg::ReleaseRun
) (
    input  tlfps_pkg::deb_state_t cur,
    input  logic                  pressed,
    output tlfps_pkg::deb_state_t nxt,
    output logic                  fire
);
    import tlfps_pkg::*;

    localparam logic [1:0] PressMax   = 2'(PRESS_RUN);
    localparam logic [5:0] ReleaseMax = 6'(RELEASE_RUN);

    // run counters and held flag
    always_comb
    begin
        nxt  = cur;
        fire = 1'b0;
        if (pressed)
        begin
            if (cur.press_run < PressMax)
                nxt.press_run = cur.press_run + 2'd1;
            nxt.release_run = '0;
            if (!cur.held && nxt.press_run >= PressMax)
            begin
                nxt.held = 1'b1;
                fire     = 1'b1;
            end
        end
        else
        begin
            if (cur.release_run < ReleaseMax)
                nxt.release_run = cur.release_run + 6'd1;
            nxt.press_run = '0;
            if (cur.held && nxt.release_run >= ReleaseMax)
                nxt.held = 1'b0;
        end
    end
endmodule

FILE: design/tlfps_pattern.sv
// pattern stepper: mode advance, re-init and the 26 flash patterns
// depends on tlfps_pkg
module tlfps_pattern (
    input  tlfps_pkg::pat_state_t cur,
    input  logic                  adv_neg,
    input  logic                  adv_pos,
    output tlfps_pkg::pat_state_t nxt
);
    import tlfps_pkg::*;

    pat_state_t s;

    function automatic pat_state_t init_pat(input pat_state_t i);
        pat_state_t o;
        o = i;
        o.drive = '0;
        o.blink_count_a = '0;
        o.blink_count_b = '0;
        o.duty_timer_a = '0;
        o.duty_timer_b = '0;
        o.start_delay = '0;
        o.pattern_phase = '0;
        o.step_counter = '0;
        o.blink_level_a = '0;
        o.blink_level_b = '0;
        o.selected_led = 2'd0;
        o.selected_mask = 2'd1;
        if (i.mode == 5'd9) o.start_delay = 10'd385;
        if (i.mode == 5'd11) o.start_delay = 10'd935;
        if (i.mode == 5'd13 || i.mode == 5'd14) o.step_counter = 8'd15;
        if (i.mode == 5'd15 || i.mode == 5'd17)
        begin
            o.selected_led = 2'd1;
            o.switch_count = '0;
            o.last_quarter_count = '0;
        end
        if (i.mode == 5'd19 || i.mode == 5'd20) o.start_delay = 10'd109;
        if (i.mode == 5'd23)
        begin
            o.first_led_phase = '0;
            o.second_led_phase = '0;
            o.first_led_subphase = '0;
            o.second_led_subphase = '0;
            o.first_led_rounds = '0;
            o.second_led_rounds = '0;
            o.start_delay = 10'd386;
        end
        return o;
    endfunction

    function automatic pat_state_t adv(input pat_state_t i);
        pat_state_t o;
        o = i;
        o.mode = (i.mode >= 5'(LastMode)) ? 5'd0 : i.mode + 5'd1;
        return init_pat(o);
    endfunction

    function automatic pat_state_t bla(input pat_state_t i, input logic [11:0] on,
                                       input logic [11:0] off);
        pat_state_t o;
        o = i;
        if (i.duty_timer_a == '0)
        begin
            if (i.blink_level_a != '0)
            begin
                o.blink_level_a = '0;
                o.duty_timer_a = off;
                o.blink_count_a = i.blink_count_a + 8'd1;
            end
            else
            begin
                o.blink_level_a = 8'hff;
                o.duty_timer_a = on;
            end
        end
        return o;
    endfunction

    function automatic pat_state_t blb(input pat_state_t i, input logic [11:0] on,
                                       input logic [11:0] off);
        pat_state_t o;
        o = i;
        if (i.duty_timer_b == '0)
        begin
            if (i.blink_level_b != '0)
            begin
                o.blink_level_b = '0;
                o.duty_timer_b = off;
                o.blink_count_b = i.blink_count_b + 8'd1;
            end
            else
            begin
                o.blink_level_b = 8'hff;
                o.duty_timer_b = on;
            end
        end
        return o;
    endfunction

    function automatic logic done_a(input pat_state_t i, input logic [7:0] n);
        return i.blink_count_a >= n && i.blink_level_a == '0 && i.duty_timer_a == '0;
    endfunction

    function automatic logic done_b(input pat_state_t i, input logic [7:0] n);
        return i.blink_count_b >= n && i.blink_level_b == '0 && i.duty_timer_b == '0;
    endfunction

    function automatic pat_state_t alternating(input pat_state_t i, input logic [11:0] fl,
                                               input logic [11:0] hold);
        pat_state_t o;
        o = i;
        if (i.pattern_phase == 2'd0)
        begin
            if (done_a(i, 8'd4))
            begin
                o.blink_count_a = '0;
                o.blink_level_a = {6'd0, i.selected_mask};
                o.drive = '0;
                o.pattern_phase = 2'd1;
                o.duty_timer_a = hold;
            end
            else
            begin
                o = bla(i, fl, fl);
                // one-hot mask of the selected led, empty when the index is past led 1
                o.selected_mask = (i.selected_led == 2'd0) ? 2'd1
                                : ((i.selected_led == 2'd1) ? 2'd2 : 2'd0);
                o.drive = o.blink_level_a[1:0] & o.selected_mask;
            end
        end
        else if (i.pattern_phase == 2'd1)
        begin
            o.drive = i.blink_level_a[1:0];
            if (i.duty_timer_a == '0)
            begin
                o.selected_led = i.selected_led ^ 2'd1;
                o.blink_count_a = '0;
                o.blink_level_a = '0;
                o.drive = '0;
                o.pattern_phase = 2'd0;
            end
        end
        return o;
    endfunction

    function automatic pat_state_t synced(input pat_state_t i, input logic [11:0] fl,
                                          input logic [11:0] hold, input logic [11:0] off);
        pat_state_t o;
        o = i;
        if (i.pattern_phase == 2'd0)
        begin
            if (done_a(i, 8'd4))
            begin
                o.blink_count_a = '0;
                o.blink_level_a = '0;
                o.pattern_phase = 2'd1;
            end
            else o = bla(i, fl, fl);
        end
        else if (i.pattern_phase == 2'd1)
        begin
            if (done_a(i, 8'd1))
            begin
                o.blink_count_a = '0;
                o.blink_level_a = '0;
                o.pattern_phase = 2'd0;
            end
            else o = bla(i, hold, off);
        end
        o.drive = o.blink_level_a[1:0];
        return o;
    endfunction

    function automatic pat_state_t staggered(input pat_state_t i, input logic [11:0] on,
                                             input logic [11:0] off, input logic swp);
        pat_state_t o;
        o = bla(i, on, off);
        if (i.start_delay == '0)
        begin
            o = blb(o, on, off);
            o.drive = swp ? {o.blink_level_a[1], o.blink_level_b[0]}
                          : {o.blink_level_b[1], o.blink_level_a[0]};
        end
        else
        begin
            o.start_delay = i.start_delay - 10'd1;
            o.drive = swp ? {o.blink_level_a[1], 1'b0} : {1'b0, o.blink_level_a[0]};
        end
        return o;
    endfunction

    function automatic pat_state_t ramp(input pat_state_t i, input logic one);
        pat_state_t o;
        logic [11:0] t;
        o = i;
        t = {4'd0, i.step_counter} * 12'd15;
        if (done_a(i, 8'd1))
        begin
            o.blink_count_a = '0;
            if (i.pattern_phase == 2'd0)
            begin
                o.step_counter = i.step_counter - 8'd1;
                if (o.step_counter == '0)
                begin
                    o.pattern_phase = 2'd1;
                    o.step_counter = 8'd1;
                end
            end
            else
            begin
                o.step_counter = i.step_counter + 8'd1;
                if (o.step_counter == 8'd15) o.pattern_phase = 2'd0;
            end
        end
        else o = bla(i, t, t);
        if (one) o.drive = (o.blink_level_a != '0) ? 2'd2 : 2'd1;
        else o.drive = (o.blink_level_a != '0) ? 2'd3 : 2'd0;
        return o;
    endfunction

    function automatic pat_state_t split_run(input pat_state_t i, input logic [11:0] t1,
                                             input logic [11:0] t2);
        pat_state_t o;
        logic [5:0] q;
        o = i;
        if (i.pattern_phase < 2'd2)
        begin
            o = bla(i, t1, t1);
            if (i.blink_level_a != '0 && o.blink_level_a == '0)
                o.selected_led = i.selected_led ^ 2'd3;
            o.drive = o.blink_level_a[1:0] & o.selected_led;
            if (o.blink_count_a >= 8'd4)
            begin
                o.blink_count_a = '0;
                o.blink_level_a = '0;
                o.pattern_phase = i.pattern_phase + 2'd1;
                if (o.pattern_phase == 2'd2)
                begin
                    o.switch_count = '0;
                    o.last_quarter_count = '0;
                end
            end
        end
        else
        begin
            o = blb(i, t2, t2);
            o.drive = o.blink_level_b[1:0] & o.selected_led;
            q = o.blink_count_b[7:2];
            if (q != '0 && q > i.last_quarter_count)
            begin
                o.selected_led = o.selected_led ^ 2'd3;
                o.last_quarter_count = q;
                o.switch_count = i.switch_count + 3'd1;
                if (o.switch_count >= 3'd4)
                begin
                    o.pattern_phase = 2'd0;
                    o.blink_count_b = '0;
                    o.blink_level_b = '0;
                    o.switch_count = '0;
                    o.last_quarter_count = '0;
                end
            end
        end
        return o;
    endfunction

    function automatic pat_state_t mode8(input pat_state_t i);
        pat_state_t o;
        o = i;
        if (i.pattern_phase == 2'd0)
        begin
            if (done_a(i, 8'd4))
            begin
                o.blink_count_a = '0;
                o.blink_level_a = '0;
                o.pattern_phase = 2'd1;
                o.duty_timer_a = 12'd1070;
            end
            else o = bla(i, 12'd119, 12'd119);
        end
        else if (i.pattern_phase == 2'd1)
        begin
            if (i.duty_timer_a == '0)
            begin
                o.blink_count_a = '0;
                o.blink_level_a = '0;
                o.pattern_phase = 2'd0;
            end
        end
        o.drive = o.blink_level_a[1:0];
        return o;
    endfunction

    function automatic pat_state_t mode16(input pat_state_t i);
        pat_state_t o;
        o = i;
        if (i.pattern_phase == 2'd0)
        begin
            if (done_a(i, 8'd4))
            begin
                o.blink_count_a = '0;
                o.pattern_phase = 2'd1;
            end
            else o = bla(i, 12'd99, 12'd299);
        end
        else if (i.pattern_phase == 2'd1)
        begin
            if (done_a(i, 8'd4))
            begin
                o.blink_count_a = '0;
                o.pattern_phase = 2'd2;
                o.start_delay = 10'd390;
            end
            else o = bla(i, 12'd49, 12'd49);
        end
        else
        begin
            if (i.start_delay != '0) o.start_delay = i.start_delay - 10'd1;
            else if (i.step_counter >= 8'd1)
            begin
                o.step_counter = '0;
                o.pattern_phase = 2'd0;
            end
            else
            begin
                o.step_counter = i.step_counter + 8'd1;
                o.pattern_phase = 2'd1;
            end
        end
        o.drive = (o.pattern_phase == 2'd2) ? 2'd0
                : ((o.blink_level_a != '0) ? 2'd3 : 2'd0);
        return o;
    endfunction

    function automatic pat_state_t mode18(input pat_state_t i);
        pat_state_t o;
        o = i;
        if (i.pattern_phase == 2'd0)
        begin
            if (done_a(i, 8'd4))
            begin
                o.blink_count_a = '0;
                o.blink_level_a = '0;
                o.pattern_phase = 2'd1;
            end
            else o = bla(i, 12'd238, 12'd711);
        end
        else if (i.pattern_phase == 2'd1)
        begin
            if (done_a(i, 8'd4))
            begin
                o.blink_count_a = '0;
                o.blink_level_a = '0;
                o.duty_timer_a = 12'd1071;
                o.pattern_phase = 2'd2;
            end
            else o = bla(i, 12'd120, 12'd120);
        end
        else if (i.duty_timer_a == '0)
        begin
            o.blink_count_a = '0;
            o.blink_level_a = '0;
            if (i.step_counter >= 8'd1)
            begin
                o.pattern_phase = 2'd0;
                o.step_counter = '0;
            end
            else
            begin
                o.step_counter = i.step_counter + 8'd1;
                o.pattern_phase = 2'd1;
            end
        end
        o.drive = o.blink_level_a[1:0];
        return o;
    endfunction

    function automatic pat_state_t clr_a(input pat_state_t i);
        pat_state_t o;
        o = i;
        o.blink_count_a = '0;
        o.blink_level_a = '0;
        return o;
    endfunction

    function automatic pat_state_t clr_b(input pat_state_t i);
        pat_state_t o;
        o = i;
        o.blink_count_b = '0;
        o.blink_level_b = '0;
        return o;
    endfunction

    function automatic pat_state_t mode23(input pat_state_t i);
        pat_state_t o;
        o = i;
        // first led sequencer
        if (i.first_led_phase == 2'd0)
        begin
            if (done_a(i, 8'd2))
            begin
                o = clr_a(o);
                o.first_led_phase = 2'd1;
                o.duty_timer_a = '0;
                o.first_led_rounds = '0;
                o.first_led_subphase = 1'b0;
            end
            else o = bla(o, 12'd290, 12'd485);
        end
        else if (i.first_led_phase == 2'd1)
        begin
            if (i.first_led_rounds >= 2'd2)
            begin
                o = clr_a(o);
                o.first_led_phase = 2'd2;
                o.duty_timer_a = '0;
                o.first_led_rounds = '0;
                o.first_led_subphase = 1'b0;
            end
            else if (!i.first_led_subphase)
            begin
                if (i.blink_count_a == 8'd4 && i.blink_level_a == '0 && i.duty_timer_a == '0)
                begin
                    o = clr_a(o);
                    o.first_led_subphase = 1'b1;
                end
                else o = bla(o, 12'd25, 12'd25);
            end
            else
            begin
                if (i.blink_count_a == 8'd1 && i.blink_level_a == '0 && i.duty_timer_a == '0)
                begin
                    o = clr_a(o);
                    o.first_led_subphase = 1'b0;
                    o.first_led_rounds = i.first_led_rounds + 2'd1;
                end
                else o = bla(o, 12'd194, 12'd399);
            end
        end
        else
        begin
            if (i.first_led_rounds >= 2'd2)
            begin
                o = clr_a(o);
                o.first_led_phase = 2'd0;
                o.duty_timer_a = '0;
                o.first_led_rounds = '0;
                o.first_led_subphase = 1'b0;
            end
            else if (!i.first_led_subphase)
            begin
                if (i.blink_count_a == 8'd4 && i.blink_level_a == '0 && i.duty_timer_a == '0)
                begin
                    o = clr_a(o);
                    o.first_led_subphase = 1'b1;
                    o.duty_timer_a = 12'd390;
                end
                else o = bla(o, 12'd50, 12'd50);
            end
            else
            begin
                o.blink_level_a = '0;
                if (i.duty_timer_a == '0)
                begin
                    o = clr_a(o);
                    o.first_led_subphase = 1'b0;
                    o.first_led_rounds = i.first_led_rounds + 2'd1;
                end
            end
        end
        // second led sequencer, after the start delay
        if (i.start_delay == '0)
        begin
            if (i.second_led_phase == 2'd0)
            begin
                if (i.second_led_rounds >= 2'd1)
                begin
                    o = clr_b(o);
                    o.duty_timer_b = '0;
                    o.second_led_subphase = 1'b0;
                    o.second_led_rounds = '0;
                    o.second_led_phase = 2'd1;
                end
                else if (!i.second_led_subphase)
                begin
                    if (done_b(i, 8'd2))
                    begin
                        o.second_led_subphase = 1'b1;
                        o = clr_b(o);
                        o.duty_timer_b = 12'd782;
                    end
                    else o = blb(o, 12'd290, 12'd97);
                end
                else if (i.duty_timer_b == '0)
                begin
                    o = clr_b(o);
                    o.second_led_subphase = 1'b0;
                    o.second_led_rounds = i.second_led_rounds + 2'd1;
                end
            end
            else if (i.second_led_phase == 2'd1)
            begin
                if (i.second_led_rounds >= 2'd2)
                begin
                    o = clr_b(o);
                    o.duty_timer_b = '0;
                    o.second_led_subphase = 1'b0;
                    o.second_led_rounds = '0;
                    o.second_led_phase = 2'd2;
                end
                else if (!i.second_led_subphase)
                begin
                    if (done_b(i, 8'd4))
                    begin
                        o = clr_b(o);
                        o.second_led_subphase = 1'b1;
                    end
                    else o = blb(o, 12'd25, 12'd25);
                end
                else
                begin
                    if (done_b(i, 8'd1))
                    begin
                        o = clr_b(o);
                        o.second_led_subphase = 1'b0;
                        o.second_led_rounds = i.second_led_rounds + 2'd1;
                    end
                    else o = blb(o, 12'd200, 12'd782);
                end
            end
            else
            begin
                if (!i.second_led_subphase)
                begin
                    if (done_b(i, 8'd8))
                    begin
                        o.second_led_subphase = 1'b1;
                        o = clr_b(o);
                        o.duty_timer_b = 12'd782;
                    end
                    else o = blb(o, 12'd50, 12'd50);
                end
                else if (i.duty_timer_b == '0)
                begin
                    o = clr_b(o);
                    o.second_led_rounds = '0;
                    o.second_led_phase = 2'd0;
                    o.second_led_subphase = 1'b0;
                end
            end
        end
        else o.start_delay = i.start_delay - 10'd1;
        o.drive = {o.blink_level_b[1], o.blink_level_a[0]};
        return o;
    endfunction

    // duty countdown, then mode advances from the debouncers
    always_comb
    begin
        s = cur;
        if (s.duty_timer_a != '0) s.duty_timer_a = s.duty_timer_a - 12'd1;
        if (s.duty_timer_b != '0) s.duty_timer_b = s.duty_timer_b - 12'd1;
        if (adv_neg) s = adv(s);
        if (adv_pos) s = adv(s);
    end

    // pattern step of the mode in force
    always_comb
    begin
        nxt = s;
        unique case (s.mode)
            5'd0:
            begin
                nxt = bla(s, 12'd1, 12'd1);
                nxt.drive = nxt.blink_level_a[1:0];
            end
            5'd1:  nxt = alternating(s, 12'd25, 12'd200);
            5'd2:  nxt = synced(s, 12'd25, 12'd200, 12'd390);
            5'd3:  nxt = alternating(s, 12'd59, 12'd470);
            5'd4:  nxt = synced(s, 12'd59, 12'd470, 12'd951);
            5'd5:  nxt = alternating(s, 12'd49, 12'd0);
            5'd6:  nxt = synced(s, 12'd49, 12'd0, 12'd439);
            5'd7:  nxt = alternating(s, 12'd119, 12'd0);
            5'd8:  nxt = mode8(s);
            5'd9:  nxt = staggered(s, 12'd289, 12'd485, 1'b0);
            5'd10:
            begin
                nxt = bla(s, 12'd290, 12'd480);
                nxt.drive = nxt.blink_level_a[1:0];
            end
            5'd11: nxt = staggered(s, 12'd698, 12'd1167, 1'b0);
            5'd12:
            begin
                nxt = bla(s, 12'd701, 12'd1161);
                nxt.drive = nxt.blink_level_a[1:0];
            end
            5'd13: nxt = ramp(s, 1'b1);
            5'd14: nxt = ramp(s, 1'b0);
            5'd15: nxt = split_run(s, 12'd99, 12'd49);
            5'd16: nxt = mode16(s);
            5'd17: nxt = split_run(s, 12'd238, 12'd120);
            5'd18: nxt = mode18(s);
            5'd19: nxt = staggered(s, 12'd109, 12'd327, 1'b0);
            5'd20: nxt = staggered(s, 12'd109, 12'd327, 1'b1);
            5'd21:
            begin
                if (s.duty_timer_a == '0)
                begin
                    nxt.duty_timer_a = 12'd109;
                    nxt.blink_count_a = s.blink_count_a + 8'd1;
                end
                nxt.drive = (nxt.blink_count_a[0]) ? 2'd1 : 2'd2;
            end
            5'd22:
            begin
                nxt = bla(s, 12'd109, 12'd109);
                nxt.drive = nxt.blink_level_a[1:0];
            end
            5'd23: nxt = mode23(s);
            5'd24:
            begin
                nxt = blb(bla(s, 12'd246, 12'd369), 12'd1, 12'd1);
                nxt.drive = {nxt.blink_level_b[1], nxt.blink_level_a[0]};
            end
            5'd25:
            begin
                nxt = blb(bla(s, 12'd246, 12'd369), 12'd1, 12'd1);
                nxt.drive = {nxt.blink_level_a[1], nxt.blink_level_b[0]};
            end
            default: nxt = s;
        endcase
    end
endmodule

FILE: design/two_led_flash_pattern_sequencer.sv
// top level of the two-led flash pattern sequencer
// the result is registered at the tick transfer and shown in the cycle after it
// throughput: one tick per cycle while no result waits stalled; state update is one combinational pass
// a waiting result stalls the input; a new tick is taken in the cycle it drains
// reset: asynchronous active low, mode 0, led selection 1, led mask 1, other pattern and key state cleared
// depends on tlfps_pkg, tlfps_debounce, tlfps_pattern
module two_led_flash_pattern_sequencer #(
    parameter int PRESS_RUN   = tlfps_pkg::PressRun,
    parameter int RELEASE_RUN = tlfps_pkg::ReleaseRun
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       neg_key_level,
    input  logic       pos_key_level,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] led_drive,
    output logic [4:0] active_mode
);
    import tlfps_pkg::*;

    pat_state_t pat_reg, pat_next, pat_step;
    deb_state_t neg_reg, neg_next, neg_adj, pos_reg, pos_next;
    logic       neg_fire, pos_fire;
    logic       out_valid_reg;
    logic [1:0] led_reg;
    logic [4:0] mode_out_reg;
    logic       take;

    function automatic pat_state_t pat_reset_val();
        pat_state_t r;
        r = '0;
        r.selected_led = 2'd1;
        r.selected_mask = 2'd1;
        return r;
    endfunction

    tlfps_debounce #(.PRESS_RUN(PRESS_RUN), .RELEASE_RUN(RELEASE_RUN)) u_neg (
        .cur(neg_reg), .pressed(!neg_key_level), .nxt(neg_next), .fire(neg_fire)
    );
    tlfps_debounce #(.PRESS_RUN(PRESS_RUN), .RELEASE_RUN(RELEASE_RUN)) u_pos (
        .cur(pos_reg), .pressed(pos_key_level), .nxt(pos_next), .fire(pos_fire)
    );
    tlfps_pattern u_pat (
        .cur(pat_reg), .adv_neg(neg_fire), .adv_pos(pos_fire), .nxt(pat_step)
    );

    // accept whenever the result slot is free or drains this cycle
    assign in_stall = out_valid_reg && out_stall;
    assign take     = in_valid && !in_stall;

    // pattern re-init on a positive key press also clears the negative release run
    always_comb
    begin
        neg_adj = neg_next;
        if (pos_fire) neg_adj.release_run = '0;
    end

    // state next value including configuration write
    always_comb
    begin
        pat_next = pat_reg;
        if (take) pat_next = pat_step;
        if (cfg_we) pat_next.mode = (cfg_wdata > 5'(LastMode)) ? 5'd0 : cfg_wdata;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg <= pat_reset_val();
            neg_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            pat_reg <= pat_next;
            if (take)
            begin
                neg_reg <= neg_adj;
                pos_reg <= pos_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            led_reg      <= pat_step.drive;
            mode_out_reg <= pat_step.mode;
        end
    end

    assign out_valid   = out_valid_reg;
    assign led_drive   = led_reg;
    assign active_mode = mode_out_reg;
endmodule

FILE: design/tlfps_checker.sv
// port-level checker for the sequencer, bound to the top level
// depends only on the top level's ports
module tlfps_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] led_drive,
    input logic [4:0] active_mode
);
    // a tick transfer always yields a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("no result after tick transfer");

    // a held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(led_drive) && $stable(active_mode))
        else $error("held result changed");

    // input is only stalled by a waiting result
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("stall without waiting result");

    // reported mode stays in range
    a_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> active_mode <= 5'd25)
        else $error("mode out of range");
endmodule

bind two_led_flash_pattern_sequencer tlfps_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .led_drive(led_drive),
    .active_mode(active_mode)
);

FILE: tb/sv/two_led_flash_pattern_sequencer_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the two-led flash pattern sequencer
// holds its own tick predictor of key debounce, mode stepping and all patterns
// depends on tlfps_pkg and the two_led_flash_pattern_sequencer top level
module two_led_flash_pattern_sequencer_tb;

    import tlfps_pkg::*;

    typedef struct packed {
        logic [1:0] led;
        logic [4:0] mode;
    } tick_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [4:0] cfg_wdata = '0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       neg_key_level = 1'b1;
    logic       pos_key_level = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] led_drive;
    logic [4:0] active_mode;

    tick_result_t expected_ticks[$];
    int errors = 0;
    int ticks_sent = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    int burst_left = 0;
    bit gaps_on = 1'b0;
    bit stall_on = 1'b0;
    int stall_cnt = 0;

    // predictor state
    bit [4:0]  pm_mode;
    bit [15:0] tmr_a, tmr_b, dly;
    bit [7:0]  lvl_a, lvl_b, cnt_a, cnt_b;
    bit [7:0]  phase, step, sel_led, sel_mask, sw_cnt, lastq;
    bit [7:0]  f_ph, f_sub, f_rnd, s_ph, s_sub, s_rnd;
    bit [7:0]  negp, negr, negh, posp, posr, posh;
    bit [7:0]  drv;

    two_led_flash_pattern_sequencer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .neg_key_level(neg_key_level),
        .pos_key_level(pos_key_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .led_drive    (led_drive),
        .active_mode  (active_mode)
    );

    always #2 clk = ~clk;

    // ---------------- predictor ----------------

    function automatic void reset_model();
        pm_mode = 0; tmr_a = 0; tmr_b = 0; dly = 0;
        lvl_a = 0; lvl_b = 0; cnt_a = 0; cnt_b = 0;
        phase = 0; step = 0; sel_led = 1; sel_mask = 1; sw_cnt = 0; lastq = 0;
        f_ph = 0; f_sub = 0; f_rnd = 0; s_ph = 0; s_sub = 0; s_rnd = 0;
        negp = 0; negr = 0; negh = 0; posp = 0; posr = 0; posh = 0;
        drv = 0;
    endfunction

    function automatic void blink_a(bit [15:0] on_t, bit [15:0] off_t);
        if (tmr_a == 0)
        begin
            if (lvl_a != 0)
            begin
                lvl_a = 0; tmr_a = off_t & 16'hfff; cnt_a++;
            end
            else
            begin
                lvl_a = 8'hff; tmr_a = on_t & 16'hfff;
            end
        end
    endfunction

    function automatic void blink_b(bit [15:0] on_t, bit [15:0] off_t);
        if (tmr_b == 0)
        begin
            if (lvl_b != 0)
            begin
                lvl_b = 0; tmr_b = off_t & 16'hfff; cnt_b++;
            end
            else
            begin
                lvl_b = 8'hff; tmr_b = on_t & 16'hfff;
            end
        end
    endfunction

    function automatic bit done_a(int n);
        return cnt_a >= n && lvl_a == 0 && tmr_a == 0;
    endfunction

    function automatic bit done_b(int n);
        return cnt_b >= n && lvl_b == 0 && tmr_b == 0;
    endfunction

    function automatic void clear_a();
        cnt_a = 0; lvl_a = 0;
    endfunction

    function automatic void clear_b();
        cnt_b = 0; lvl_b = 0;
    endfunction

    // pattern restart after a mode step
    function automatic void restart_pattern();
        drv = 0; cnt_a = 0; cnt_b = 0; negr = 0; tmr_a = 0; tmr_b = 0;
        dly = 0; phase = 0; step = 0; lvl_a = 0; lvl_b = 0;
        sel_led = 0; sel_mask = 1;
        if (pm_mode == 9) dly = 385;
        if (pm_mode == 11) dly = 935;
        if (pm_mode == 13 || pm_mode == 14) step = 15;
        if (pm_mode == 15 || pm_mode == 17)
        begin
            sel_led = 1; sw_cnt = 0; lastq = 0;
        end
        if (pm_mode == 19 || pm_mode == 20) dly = 109;
        if (pm_mode == 23)
        begin
            f_ph = 0; s_ph = 0; f_sub = 0; s_sub = 0; f_rnd = 0; s_rnd = 0;
            dly = 386;
        end
    endfunction

    function automatic void step_mode();
        pm_mode = (pm_mode >= LastMode) ? 5'd0 : pm_mode + 5'd1;
        restart_pattern();
    endfunction

    function automatic void alternating(bit [15:0] flash, bit [15:0] hold);
        if (phase == 0)
        begin
            if (done_a(4))
            begin
                cnt_a = 0; lvl_a = sel_mask; drv = 0; phase = 1; tmr_a = hold & 16'hfff;
            end
            else
            begin
                blink_a(flash, flash);
                sel_mask = 8'((1 << (sel_led & 3)) & 3);
                drv = lvl_a & sel_mask;
            end
        end
        else if (phase == 1)
        begin
            drv = lvl_a;
            if (tmr_a == 0)
            begin
                sel_led ^= 1; clear_a(); drv = 0; phase = 0;
            end
        end
    endfunction

    function automatic void synchronized(bit [15:0] flash, bit [15:0] hold, bit [15:0] off_t);
        if (phase == 0)
        begin
            if (done_a(4))
            begin
                clear_a(); phase = 1;
            end
            else blink_a(flash, flash);
        end
        else if (phase == 1)
        begin
            if (done_a(1))
            begin
                clear_a(); phase = 0;
            end
            else blink_a(hold, off_t);
        end
        drv = lvl_a & 3;
    endfunction

    function automatic void staggered(bit [15:0] on_t, bit [15:0] off_t, bit swap);
        blink_a(on_t, off_t);
        if (dly == 0)
        begin
            blink_b(on_t, off_t);
            drv = swap ? ((lvl_a & 2) | (lvl_b & 1)) : ((lvl_a & 1) | (lvl_b & 2));
        end
        else
        begin
            dly--;
            drv = lvl_a & (swap ? 8'd2 : 8'd1);
        end
    endfunction

    function automatic void ramp(bit one_led);
        bit [15:0] t;
        t = 16'(step * 15);
        if (done_a(1))
        begin
            cnt_a = 0;
            if (phase == 0)
            begin
                step--;
                if (step == 0)
                begin
                    phase = 1; step = 1;
                end
            end
            else
            begin
                step++;
                if (step == 15) phase = 0;
            end
        end
        else blink_a(t, t);
        if (one_led) drv = (lvl_a != 0) ? 8'd2 : 8'd1;
        else drv = (lvl_a != 0) ? 8'd3 : 8'd0;
    endfunction

    function automatic void split_run(bit [15:0] t1, bit [15:0] t2);
        bit [7:0] prev;
        bit [7:0] q;
        if (phase < 2)
        begin
            prev = lvl_a;
            blink_a(t1, t1);
            if (prev != 0 && lvl_a == 0) sel_led ^= 3;
            drv = lvl_a & sel_led;
            if (cnt_a >= 4)
            begin
                clear_a(); phase++;
                if (phase == 2)
                begin
                    sw_cnt = 0; lastq = 0;
                end
            end
        end
        else
        begin
            blink_b(t2, t2);
            drv = lvl_b & sel_led;
            q = cnt_b >> 2;
            if (q > 0 && q > lastq)
            begin
                sel_led ^= 3; lastq = q & 63; sw_cnt++;
                if (sw_cnt >= 4)
                begin
                    phase = 0; clear_b(); sw_cnt = 0; lastq = 0;
                end
            end
        end
    endfunction

    function automatic void pattern8();
        if (phase == 0)
        begin
            if (done_a(4))
            begin
                clear_a(); phase = 1; tmr_a = 1070;
            end
            else blink_a(119, 119);
        end
        else if (phase == 1)
        begin
            if (tmr_a == 0)
            begin
                clear_a(); phase = 0;
            end
        end
        drv = lvl_a & 3;
    endfunction

    function automatic void pattern16();
        if (phase == 0)
        begin
            if (done_a(4))
            begin
                cnt_a = 0; phase = 1;
            end
            else blink_a(99, 299);
        end
        else if (phase == 1)
        begin
            if (done_a(4))
            begin
                cnt_a = 0; phase = 2; dly = 390;
            end
            else blink_a(49, 49);
        end
        else
        begin
            if (dly > 0) dly--;
            else if (step >= 1)
            begin
                step = 0; phase = 0;
            end
            else
            begin
                step++; phase = 1;
            end
        end
        drv = (phase == 2) ? 8'd0 : ((lvl_a != 0) ? 8'd3 : 8'd0);
    endfunction

    function automatic void pattern18();
        if (phase == 0)
        begin
            if (done_a(4))
            begin
                clear_a(); phase = 1;
            end
            else blink_a(238, 711);
        end
        else if (phase == 1)
        begin
            if (done_a(4))
            begin
                clear_a(); tmr_a = 1071; phase = 2;
            end
            else blink_a(120, 120);
        end
        else if (tmr_a == 0)
        begin
            clear_a();
            if (step >= 1)
            begin
                phase = 0; step = 0;
            end
            else
            begin
                step++; phase = 1;
            end
        end
        drv = lvl_a & 3;
    endfunction

    function automatic void pattern23();
        // first led sequence
        if (f_ph == 0)
        begin
            if (done_a(2))
            begin
                clear_a(); f_ph = 1; tmr_a = 0; f_rnd = 0; f_sub = 0;
            end
            else blink_a(290, 485);
        end
        else if (f_ph == 1)
        begin
            if (f_rnd >= 2)
            begin
                clear_a(); f_ph = 2; tmr_a = 0; f_rnd = 0; f_sub = 0;
            end
            else if (f_sub == 0)
            begin
                if (cnt_a == 4 && lvl_a == 0 && tmr_a == 0)
                begin
                    clear_a(); f_sub = 1;
                end
                else blink_a(25, 25);
            end
            else
            begin
                if (cnt_a == 1 && lvl_a == 0 && tmr_a == 0)
                begin
                    clear_a(); f_sub = 0; f_rnd++;
                end
                else blink_a(194, 399);
            end
        end
        else
        begin
            if (f_rnd >= 2)
            begin
                clear_a(); f_ph = 0; tmr_a = 0; f_rnd = 0; f_sub = 0;
            end
            else if (f_sub == 0)
            begin
                if (cnt_a == 4 && lvl_a == 0 && tmr_a == 0)
                begin
                    clear_a(); f_sub = 1; tmr_a = 390;
                end
                else blink_a(50, 50);
            end
            else
            begin
                lvl_a = 0;
                if (tmr_a == 0)
                begin
                    clear_a(); f_sub = 0; f_rnd++;
                end
            end
        end
        // second led sequence after its start delay
        if (dly == 0)
        begin
            if (s_ph == 0)
            begin
                if (s_rnd >= 1)
                begin
                    clear_b(); tmr_b = 0; s_sub = 0; s_rnd = 0; s_ph = 1;
                end
                else if (s_sub == 0)
                begin
                    if (done_b(2))
                    begin
                        s_sub = 1; clear_b(); tmr_b = 782;
                    end
                    else blink_b(290, 97);
                end
                else if (tmr_b == 0)
                begin
                    clear_b(); s_sub = 0; s_rnd++;
                end
            end
            else if (s_ph == 1)
            begin
                if (s_rnd >= 2)
                begin
                    clear_b(); tmr_b = 0; s_sub = 0; s_rnd = 0; s_ph = 2;
                end
                else if (s_sub == 0)
                begin
                    if (done_b(4))
                    begin
                        clear_b(); s_sub = 1;
                    end
                    else blink_b(25, 25);
                end
                else
                begin
                    if (done_b(1))
                    begin
                        clear_b(); s_sub = 0; s_rnd++;
                    end
                    else blink_b(200, 782);
                end
            end
            else
            begin
                if (s_sub == 0)
                begin
                    if (done_b(8))
                    begin
                        s_sub = 1; clear_b(); tmr_b = 782;
                    end
                    else blink_b(50, 50);
                end
                else if (tmr_b == 0)
                begin
                    clear_b(); s_rnd = 0; s_ph = 0; s_sub = 0;
                end
            end
        end
        else dly--;
        drv = (lvl_a & 1) | (lvl_b & 2);
    endfunction

    function automatic void run_pattern();
        case (pm_mode)
            0: begin blink_a(1, 1); drv = lvl_a; end
            1: alternating(25, 200);
            2: synchronized(25, 200, 390);
            3: alternating(59, 470);
            4: synchronized(59, 470, 951);
            5: alternating(49, 0);
            6: synchronized(49, 0, 439);
            7: alternating(119, 0);
            8: pattern8();
            9: staggered(289, 485, 1'b0);
            10: begin blink_a(290, 480); drv = lvl_a & 3; end
            11: staggered(698, 1167, 1'b0);
            12: begin blink_a(701, 1161); drv = lvl_a & 3; end
            13: ramp(1'b1);
            14: ramp(1'b0);
            15: split_run(99, 49);
            16: pattern16();
            17: split_run(238, 120);
            18: pattern18();
            19: staggered(109, 327, 1'b0);
            20: staggered(109, 327, 1'b1);
            21:
            begin
                if (tmr_a == 0)
                begin
                    tmr_a = 109; cnt_a++;
                end
                drv = 8'(1 << (8'(cnt_a - 8'd1) & 1));
            end
            22: begin blink_a(109, 109); drv = lvl_a & 3; end
            23: pattern23();
            24:
            begin
                blink_a(246, 369); blink_b(1, 1);
                drv = (lvl_a & 1) | (lvl_b & 2);
            end
            25:
            begin
                blink_a(246, 369); blink_b(1, 1);
                drv = (lvl_a & 2) | (lvl_b & 1);
            end
            default: ;
        endcase
        drv &= 3;
    endfunction

    // one tick: timers, both debouncers, then the pattern
    function automatic tick_result_t predict_tick(bit neg_lvl, bit pos_lvl);
        tick_result_t r;
        if (tmr_a > 0) tmr_a--;
        if (tmr_b > 0) tmr_b--;
        if (!neg_lvl)
        begin
            if (negp < PressRun) negp++;
            negr = 0;
            if (!negh && negp >= PressRun)
            begin
                negh = 1; step_mode();
            end
        end
        else
        begin
            if (negr < ReleaseRun) negr++;
            negp = 0;
            if (negh && negr >= ReleaseRun) negh = 0;
        end
        if (pos_lvl)
        begin
            if (posp < PressRun) posp++;
            posr = 0;
            if (!posh && posp >= PressRun)
            begin
                posh = 1; step_mode();
            end
        end
        else
        begin
            if (posr < ReleaseRun) posr++;
            posp = 0;
            if (posh && posr >= ReleaseRun) posh = 0;
        end
        run_pattern();
        r.led = drv[1:0];
        r.mode = pm_mode;
        return r;
    endfunction

    // ---------------- driving ----------------

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // one tick transfer, in bursts with random gaps
    task automatic send_tick(bit neg_lvl, bit pos_lvl);
        int gap;
        if (burst_left == 0)
        begin
            gap = gaps_on ? $urandom_range(0, 5) : 0;
            repeat (gap)
            begin
                @(negedge clk);
                in_valid = 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        in_valid = 1'b1;
        neg_key_level = neg_lvl;
        pos_key_level = pos_lvl;
        do @(posedge clk); while (in_stall);
        expected_ticks.push_back(predict_tick(neg_lvl, pos_lvl));
        ticks_sent++;
        burst_left--;
    endtask

    // let every expected result arrive, then let the interface sit quiet
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_ticks.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_start_mode(bit [4:0] value);
        drain_results();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        cfg_wdata = $urandom_range(0, 31);
        pm_mode = (value > LastMode) ? 5'd0 : value;
        cfg_writes++;
    endtask

    task automatic send_released(int n);
        repeat (n) send_tick(1'b1, 1'b0);
    endtask

    // receiver stall pattern: random stalls plus a periodic long stall
    always @(negedge clk)
    begin
        stall_cnt <= stall_cnt + 1;
        out_stall <= stall_on && (($urandom_range(0, 3) == 0) || (stall_cnt[5:3] == 3'b111));
    end

    // result check against the oldest expected tick
    always @(posedge clk)
    begin
        tick_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_ticks.size() == 0)
                report_mismatch("result transfer with no tick pending");
            else
            begin
                exp_r = expected_ticks.pop_front();
                if (led_drive !== exp_r.led)
                    report_mismatch($sformatf("led_drive %b expected %b (mode %0d)",
                        led_drive, exp_r.led, exp_r.mode));
                if (active_mode !== exp_r.mode)
                    report_mismatch($sformatf("active_mode %0d expected %0d",
                        active_mode, exp_r.mode));
            end
        end
    end

    // ---------------- tests ----------------

    // both keys, key level extremes, simultaneous press steps the mode twice
    task automatic test_key_levels();
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
    endtask

    // start mode extremes, out of range value and the power-up ramp wrap
    task automatic test_start_modes();
        write_start_mode(5'd31);
        send_released(3);
        write_start_mode(5'd26);
        send_released(2);
        write_start_mode(5'(LastMode));
        send_released(3);
        write_start_mode(5'd13);
        send_released(4);
        write_start_mode(5'd0);
        send_released(2);
    endtask

    // debounced key sequences with random content, dwells and noise
    task automatic test_key_sequences(int n_items);
        int goal;
        int n;
        int kind;
        bit pressed_neg;
        bit pressed_pos;
        bit paused;
        goal = ticks_sent + n_items;
        paused = 1'b0;
        while (ticks_sent < goal)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 10)
                write_start_mode(5'($urandom_range(0, 31)));
            else if (kind < 70)
            begin
                send_released($urandom_range(58, 80));
                n = $urandom_range(2, 8);
                case ($urandom_range(0, 2))
                    0: begin pressed_neg = 1; pressed_pos = 0; end
                    1: begin pressed_neg = 0; pressed_pos = 1; end
                    default: begin pressed_neg = 1; pressed_pos = 1; end
                endcase
                repeat (n) send_tick(!pressed_neg, pressed_pos);
            end
            else if (kind < 85)
                send_released($urandom_range(60, 200));
            else
                repeat ($urandom_range(1, 10))
                    send_tick($urandom_range(0, 1), $urandom_range(0, 1));
            gaps_on = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            // sender hold-off until every result is back
            if (!paused && ticks_sent > goal - n_items / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        reset_model();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        test_key_levels();
        test_start_modes();
        test_key_sequences(1000);
        drain_results();
        $display("ran %0d ticks and %0d results over %0d start mode writes",
            ticks_sent, results_seen, cfg_writes);
        $display("with key debounce, mode wrap and random stalls on both sides");
        if (errors == 0 && expected_ticks.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("timeout waiting for results");
        $display("Regression FAIL");
        $finish;
    end

endmodule
